// File: hw/rtl/jcr_pkg.sv
// Package: shared types, opcode codes and the decoder for the jump/call/return unit.
`default_nettype none

package jcr_pkg;

  localparam int unsigned STACK_BYTES_DEF = 256;
  localparam int unsigned CFG_ADDR_W      = 3;
  localparam int unsigned CFG_DATA_W      = 32;

  // Register index (paddr[2]) of the only configuration register.
  localparam logic REG_CMOS_EXTRA = 1'b0;

  localparam logic [7:0] OP_JSR_ABS  = 8'h20;
  localparam logic [7:0] OP_JSL_LONG = 8'h22;
  localparam logic [7:0] OP_JSR_IDX  = 8'hFC;
  localparam logic [7:0] OP_JMP_ABS  = 8'h4C;
  localparam logic [7:0] OP_JMP_IND  = 8'h6C;
  localparam logic [7:0] OP_JMP_IDX  = 8'h7C;
  localparam logic [7:0] OP_JML_LONG = 8'h5C;
  localparam logic [7:0] OP_JML_IND  = 8'hDC;
  localparam logic [7:0] OP_RTL      = 8'h6B;
  localparam logic [7:0] OP_RTS      = 8'h60;

  typedef struct packed {
    logic [7:0]  opcode;
    logic [7:0]  pc_bank;
    logic [15:0] pc_offset;
    logic [7:0]  target_bank;
    logic [15:0] target_offset;
  } jcr_in_t;

  typedef struct packed {
    logic [7:0]  next_bank;
    logic [15:0] next_offset;
    logic [3:0]  cycle_count;
    logic        bad_opcode;
  } jcr_out_t;

  typedef struct packed {
    logic       bad;
    logic       take_tbank;  // destination bank comes from the target
    logic       push;        // pushes a return address
    logic       pull;        // pulls a return address
    logic       long_form;   // three bytes on the stack instead of two
    logic [3:0] cycles;
  } jcr_dec_t;

  // Command from the front end to the stack.
  typedef struct packed {
    logic en;
    logic push;
    logic pull;
    logic long_form;
  } jcr_stk_cmd_t;

  function automatic jcr_dec_t jcr_decode(input logic [7:0] op, input logic cmos_extra);
    jcr_dec_t d;
    d = '0;
    case (op)
      OP_JSR_ABS: begin
        d.push = 1'b1; d.cycles = 4'd6;
      end
      OP_JSL_LONG: begin
        d.push = 1'b1; d.long_form = 1'b1; d.take_tbank = 1'b1; d.cycles = 4'd8;
      end
      OP_JSR_IDX: begin
        d.push = 1'b1; d.cycles = 4'd8;
      end
      OP_JMP_ABS: begin
        d.cycles = 4'd3;
      end
      OP_JMP_IND: begin
        d.cycles = 4'd5 + {3'd0, cmos_extra};
      end
      OP_JMP_IDX: begin
        d.cycles = 4'd6;
      end
      OP_JML_LONG: begin
        d.take_tbank = 1'b1; d.cycles = 4'd4;
      end
      OP_JML_IND: begin
        d.take_tbank = 1'b1; d.cycles = 4'd6;
      end
      OP_RTL: begin
        d.pull = 1'b1; d.long_form = 1'b1; d.cycles = 4'd6;
      end
      OP_RTS: begin
        d.pull = 1'b1; d.cycles = 4'd6;
      end
      default: begin
        d.bad = 1'b1;
      end
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/jcr_stack.sv
// Return-address stack: pointer plus four byte-interleaved banks, up to three bytes per cycle.
`default_nettype none

module jcr_stack
  import jcr_pkg::*;
#(
  parameter int unsigned STACK_BYTES = STACK_BYTES_DEF  // power of two, 16..65536
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire jcr_stk_cmd_t       cmd,
  input  wire logic [2:0][7:0]    push_bytes,  // slot 0 goes to the pointer, then downwards
  output logic      [2:0][7:0]    pull_bytes   // slot 0 from pointer+1, then upwards
);

  localparam int unsigned SP_W       = $clog2(STACK_BYTES);
  localparam int unsigned IDX_W      = SP_W - 2;
  localparam int unsigned BANK_DEPTH = STACK_BYTES / 4;

  logic [SP_W-1:0] sp_r, sp_nxt;
  logic [SP_W-1:0] addr [3];
  logic [2:0]      slot_used;
  logic [3:0]      we;
  logic [IDX_W-1:0] wa [4];
  logic [IDX_W-1:0] ra [4];
  logic [7:0]      wd [4];
  logic [7:0]      rdata_r [4];
  logic [1:0]      sel_r [3];

  always_comb begin
    slot_used = {cmd.long_form, 2'b11};
    for (int j = 0; j < 3; j++) begin
      if (cmd.push) begin
        addr[j] = sp_r - SP_W'(j);
      end else begin
        addr[j] = sp_r + SP_W'(j + 1);
      end
    end
    for (int b = 0; b < 4; b++) begin
      we[b] = 1'b0;
      wa[b] = addr[0][SP_W-1:2];
      ra[b] = addr[0][SP_W-1:2];
      wd[b] = push_bytes[0];
      for (int j = 0; j < 3; j++) begin
        if (addr[j][1:0] == 2'(b)) begin
          wa[b] = addr[j][SP_W-1:2];
          ra[b] = addr[j][SP_W-1:2];
          wd[b] = push_bytes[j];
          if (cmd.en && cmd.push && slot_used[j]) begin
            we[b] = 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    sp_nxt = sp_r;
    if (cmd.en && cmd.push) begin
      sp_nxt = sp_r - (cmd.long_form ? SP_W'(3) : SP_W'(2));
    end else if (cmd.en && cmd.pull) begin
      sp_nxt = sp_r + (cmd.long_form ? SP_W'(3) : SP_W'(2));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r <= '1;
    end else begin
      sp_r <= sp_nxt;
    end
  end

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [7:0] mem [BANK_DEPTH];

    always_ff @(posedge clk) begin
      if (we[b]) begin
        mem[wa[b]] <= wd[b];
      end
      if (cmd.en && cmd.pull) begin
        rdata_r[b] <= mem[ra[b]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.en && cmd.pull) begin
      for (int j = 0; j < 3; j++) begin
        sel_r[j] <= addr[j][1:0];
      end
    end
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      pull_bytes[j] = rdata_r[sel_r[j]];
    end
  end

  // Consecutive bytes must land in distinct banks.
  a_write_banks: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(we) == ((cmd.en && cmd.push) ? (cmd.long_form ? 3 : 2) : 0))
    else $error("stack bank write count mismatch");

  a_idle_sp: assert property (@(posedge clk) disable iff (!rst_n)
    (!cmd.en || (!cmd.push && !cmd.pull)) |=> sp_r == $past(sp_r))
    else $error("stack pointer moved without stack traffic");

  a_one_dir: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.en |-> !(cmd.push && cmd.pull))
    else $error("push and pull in one command");

endmodule

`default_nettype wire

// File: hw/rtl/jump_call_return_unit.sv
// Top level: 65816 JMP/JML/JSR/JSL/RTS/RTL execution with return-address stack.
//
//  channel  | direction | handshake             | word
//  ---------+-----------+-----------------------+-----------------------------------
//  in_      | in        | in_valid / in_stall   | jcr_in_t: opcode, PC, target
//  out_     | out       | out_valid / out_stall | jcr_out_t: next PC, cycles, bad flag
//  APB      | in/out    | psel/penable/pready   | cmos_extra_cycle at byte address 0
//
// One word per cycle while out_stall is low; a word passes s1_valid_r, then out_valid_r.
// The stack is four byte-interleaved banks with registered reads, which sets the
// extra stage: pushes write at acceptance, pulls read at acceptance and the data
// is merged in the second stage. Reset needs no clearing pass. A stalled output holds
// the second stage; in_stall rises in reset, or when both stages are full and stalled.
`default_nettype none

module jump_call_return_unit
  import jcr_pkg::*;
#(
  parameter int unsigned STACK_BYTES = STACK_BYTES_DEF  // power of two, 16..65536
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // input channel
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire jcr_in_t               in_data,
  // result channel
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output jcr_out_t                   out_data,
  // configuration (APB)
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready
);

  // ---- configuration ----
  logic cmos_r;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmos_r <= 1'b0;
    end else if (psel && penable && pwrite &&
                 paddr[CFG_ADDR_W-1:2] == REG_CMOS_EXTRA) begin
      cmos_r <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[CFG_ADDR_W-1:2] == REG_CMOS_EXTRA) begin
      prdata[0] = cmos_r;
    end
  end

  // ---- stage 1: decode, stack command, push data ----
  logic          accept;
  logic          adv;       // output register free or being emptied
  logic          s1_valid_r;
  jcr_dec_t      dec;
  jcr_dec_t      s1_dec_r;
  logic [7:0]    s1_pb_r, s1_tb_r;
  logic [15:0]   s1_pc_r, s1_to_r;
  logic [15:0]   ret_off;
  logic [2:0][7:0] push_bytes;
  logic [2:0][7:0] pull_bytes;
  jcr_stk_cmd_t  stk_cmd;
  logic          out_valid_r;
  jcr_out_t      out_data_r, out_data_nxt;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !rst_n || (s1_valid_r && !adv);
  assign accept   = in_valid && !in_stall;

  assign dec     = jcr_decode(in_data.opcode, cmos_r);
  assign ret_off = in_data.pc_offset + (dec.long_form ? 16'd3 : 16'd2);

  // JSL stacks the bank first; short calls begin with the high offset byte.
  always_comb begin
    if (dec.long_form) begin
      push_bytes = {ret_off[7:0], ret_off[15:8], in_data.pc_bank};
    end else begin
      push_bytes = {8'h00, ret_off[7:0], ret_off[15:8]};
    end
  end

  always_comb begin
    stk_cmd.en        = accept;
    stk_cmd.push      = dec.push;
    stk_cmd.pull      = dec.pull;
    stk_cmd.long_form = dec.long_form;
  end

  jcr_stack #(
    .STACK_BYTES(STACK_BYTES)
  ) u_stack (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (stk_cmd),
    .push_bytes (push_bytes),
    .pull_bytes (pull_bytes)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_dec_r <= dec;
      s1_pb_r  <= in_data.pc_bank;
      s1_pc_r  <= in_data.pc_offset;
      s1_tb_r  <= in_data.target_bank;
      s1_to_r  <= in_data.target_offset;
    end
  end

  // ---- stage 2: merge pulled bytes, result register ----
  always_comb begin
    out_data_nxt.cycle_count = s1_dec_r.cycles;
    out_data_nxt.bad_opcode  = s1_dec_r.bad;
    out_data_nxt.next_bank   = s1_pb_r;
    out_data_nxt.next_offset = s1_to_r;
    if (s1_dec_r.bad) begin
      out_data_nxt.next_offset = s1_pc_r;
    end else if (s1_dec_r.pull) begin
      // returns resume one past the stacked address
      out_data_nxt.next_offset = {pull_bytes[1], pull_bytes[0]} + 16'd1;
      if (s1_dec_r.long_form) begin
        out_data_nxt.next_bank = pull_bytes[2];
      end
    end else if (s1_dec_r.take_tbank) begin
      out_data_nxt.next_bank = s1_tb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid_r) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---- checks ----
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.bad_opcode == (out_data_r.cycle_count == 4'd0)))
    else $error("bad flag and cycle count disagree");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !adv) |=> s1_valid_r)
    else $error("stage 1 word lost under stall");

  a_s1_move: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && adv) |=> out_valid_r)
    else $error("stage 1 word not moved to output");

endmodule

`default_nettype wire
